// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define ASSERT_IMPL(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, clocked on clk, disabled in reset
`define ASSERT_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/mks_pkg.sv =====
// Types, codes and microprogram of the Monod kinetics midpoint integrator
package mks_pkg;

	// register indexes of the configuration port
	localparam logic [2:0] REG_STEP_SIZE = 3'd0;
	localparam logic [2:0] REG_GROWTH_YIELD = 3'd1;
	localparam logic [2:0] REG_PRODUCT_YIELD = 3'd2;
	localparam logic [2:0] REG_MAX_UPTAKE = 3'd3;
	localparam logic [2:0] REG_BIOMASS_CAP = 3'd4;
	localparam logic [2:0] REG_GLUCOSE_HALF_SAT = 3'd5;
	localparam logic [2:0] REG_OXYGEN_HALF_SAT = 3'd6;

	// register reset values
	localparam logic [31:0] RST_STEP_SIZE = 32'd655;
	localparam logic [31:0] RST_GROWTH_YIELD = 32'd7549747;
	localparam logic [31:0] RST_PRODUCT_YIELD = 32'd11240735;
	localparam logic [31:0] RST_MAX_UPTAKE = 32'd75497472;
	localparam logic [31:0] RST_BIOMASS_CAP = 32'd132540006;
	localparam logic [31:0] RST_GLUCOSE_HALF_SAT = 32'd1207960;
	localparam logic [31:0] RST_OXYGEN_HALF_SAT = 32'd12918;

	// 1.0 in Q8.24
	localparam logic signed [32:0] ONE_Q24 = 33'sd16777216;

	// error flag codes
	localparam logic [1:0] FLAG_SAT = 2'b01;
	localparam logic [1:0] FLAG_ZERO_STEP = 2'b10;

	typedef struct packed {
		logic [31:0] step_size;
		logic [31:0] growth_yield;
		logic [31:0] product_yield;
		logic [31:0] max_uptake;
		logic [31:0] biomass_cap;
		logic [31:0] glucose_half_sat;
		logic [31:0] oxygen_half_sat;
	} cfg_t;

	// shared unit operations
	typedef logic [2:0] alu_op_t;
	localparam alu_op_t OP_MUL = 3'd0;
	localparam alu_op_t OP_ADD = 3'd1;
	localparam alu_op_t OP_SUB = 3'd2;
	localparam alu_op_t OP_DIVQ = 3'd3;
	localparam alu_op_t OP_NDIV = 3'd4;

	// product shift select
	typedef logic [1:0] shsel_t;
	localparam shsel_t SH16 = 2'd0;
	localparam shsel_t SH17 = 2'd1;
	localparam shsel_t SH24 = 2'd2;

	typedef struct packed {
		logic start;
		alu_op_t op;
		logic signed [32:0] a;
		logic signed [32:0] b;
		shsel_t sh;
		logic plain;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic signed [31:0] res;
		logic [32:0] quot;
		logic sat;
		logic same;
	} alu_rsp_t;

	// scratch memory addresses
	typedef logic [3:0] maddr_t;
	localparam maddr_t M_X = 4'd0;
	localparam maddr_t M_G = 4'd1;
	localparam maddr_t M_M = 4'd2;
	localparam maddr_t M_O = 4'd3;
	localparam maddr_t M_EX = 4'd4;
	localparam maddr_t M_EG = 4'd5;
	localparam maddr_t M_FE = 4'd6;
	localparam maddr_t M_FS = 4'd7;
	localparam maddr_t M_T = 4'd8;
	localparam maddr_t M_QS = 4'd9;
	localparam maddr_t M_LOGI = 4'd10;
	localparam maddr_t M_RX = 4'd11;
	localparam maddr_t M_RG = 4'd12;
	localparam maddr_t M_RM = 4'd13;

	// operand sources: top bit set selects a register or constant
	typedef logic [4:0] src_t;
	localparam src_t S_X = {1'b0, M_X};
	localparam src_t S_G = {1'b0, M_G};
	localparam src_t S_M = {1'b0, M_M};
	localparam src_t S_O = {1'b0, M_O};
	localparam src_t S_EX = {1'b0, M_EX};
	localparam src_t S_EG = {1'b0, M_EG};
	localparam src_t S_FE = {1'b0, M_FE};
	localparam src_t S_FS = {1'b0, M_FS};
	localparam src_t S_T = {1'b0, M_T};
	localparam src_t S_QS = {1'b0, M_QS};
	localparam src_t S_LOGI = {1'b0, M_LOGI};
	localparam src_t S_RX = {1'b0, M_RX};
	localparam src_t S_RG = {1'b0, M_RG};
	localparam src_t S_RM = {1'b0, M_RM};
	localparam src_t S_DT = 5'd16;
	localparam src_t S_YX = 5'd17;
	localparam src_t S_YP = 5'd18;
	localparam src_t S_MU = 5'd19;
	localparam src_t S_CAP = 5'd20;
	localparam src_t S_KS = 5'd21;
	localparam src_t S_KO = 5'd22;
	localparam src_t S_ONE = 5'd23;
	localparam src_t S_ZERO = 5'd24;

	typedef struct packed {
		alu_op_t op;
		src_t sa;
		src_t sb;
		maddr_t dst;
		shsel_t sh;
		logic plain;
		logic chk;
	} uop_t;

	typedef logic [5:0] pc_t;
	localparam pc_t PC_FE = 6'd0;
	localparam pc_t PC_STEP = 6'd1;
	localparam pc_t PC_EVAL_A = 6'd3;
	localparam pc_t PC_EVAL_B = 6'd21;
	localparam pc_t EVAL_LEN = 6'd12;
	localparam pc_t PC_LAST = 6'd38;

	function automatic uop_t mk(alu_op_t op, src_t sa, src_t sb, maddr_t dst, shsel_t sh,
		logic plain, logic chk);
		uop_t u;
		u.op = op;
		u.sa = sa;
		u.sb = sb;
		u.dst = dst;
		u.sh = sh;
		u.plain = plain;
		u.chk = chk;
		return u;
	endfunction

	// one rate evaluation on EX, EG
	function automatic uop_t eval_uop(logic [3:0] k);
		uop_t u;
		unique case (k)
			4'd0: u = mk(OP_DIVQ, S_EG, S_KS, M_FS, SH24, 1'b0, 1'b0);
			4'd1: u = mk(OP_MUL, S_MU, S_FS, M_T, SH24, 1'b0, 1'b0);
			4'd2: u = mk(OP_MUL, S_T, S_FE, M_QS, SH24, 1'b0, 1'b0);
			4'd3: u = mk(OP_DIVQ, S_EX, S_CAP, M_T, SH24, 1'b1, 1'b0);
			4'd4: u = mk(OP_SUB, S_ONE, S_T, M_LOGI, SH24, 1'b0, 1'b0);
			4'd5: u = mk(OP_MUL, S_YX, S_QS, M_T, SH24, 1'b0, 1'b0);
			4'd6: u = mk(OP_MUL, S_T, S_EX, M_T, SH24, 1'b0, 1'b0);
			4'd7: u = mk(OP_MUL, S_T, S_LOGI, M_RX, SH24, 1'b0, 1'b0);
			4'd8: u = mk(OP_MUL, S_QS, S_EX, M_T, SH24, 1'b0, 1'b0);
			4'd9: u = mk(OP_SUB, S_ZERO, S_T, M_RG, SH24, 1'b0, 1'b0);
			4'd10: u = mk(OP_MUL, S_YP, S_QS, M_T, SH24, 1'b0, 1'b0);
			4'd11: u = mk(OP_MUL, S_T, S_EX, M_RM, SH24, 1'b0, 1'b0);
			default: u = mk(OP_ADD, S_ZERO, S_ZERO, M_T, SH24, 1'b0, 1'b0);
		endcase
		return u;
	endfunction

	// microprogram: oxygen factor once, then the step loop
	function automatic uop_t uop_rom(pc_t pc);
		uop_t u;
		unique case (pc)
			PC_FE: u = mk(OP_DIVQ, S_O, S_KO, M_FE, SH24, 1'b0, 1'b0);
			6'd1: u = mk(OP_ADD, S_X, S_ZERO, M_EX, SH24, 1'b0, 1'b0);
			6'd2: u = mk(OP_ADD, S_G, S_ZERO, M_EG, SH24, 1'b0, 1'b0);
			// half step
			6'd15: u = mk(OP_MUL, S_RX, S_DT, M_T, SH17, 1'b0, 1'b0);
			6'd16: u = mk(OP_ADD, S_X, S_T, M_EX, SH24, 1'b0, 1'b0);
			6'd17: u = mk(OP_MUL, S_RG, S_DT, M_T, SH17, 1'b0, 1'b0);
			6'd18: u = mk(OP_ADD, S_G, S_T, M_EG, SH24, 1'b0, 1'b0);
			6'd19: u = mk(OP_MUL, S_RM, S_DT, M_T, SH17, 1'b0, 1'b0);
			6'd20: u = mk(OP_ADD, S_M, S_T, M_T, SH24, 1'b0, 1'b0);
			// full step, written back in place
			6'd33: u = mk(OP_MUL, S_RX, S_DT, M_T, SH16, 1'b0, 1'b0);
			6'd34: u = mk(OP_ADD, S_X, S_T, M_X, SH24, 1'b0, 1'b1);
			6'd35: u = mk(OP_MUL, S_RG, S_DT, M_T, SH16, 1'b0, 1'b0);
			6'd36: u = mk(OP_ADD, S_G, S_T, M_G, SH24, 1'b0, 1'b1);
			6'd37: u = mk(OP_MUL, S_RM, S_DT, M_T, SH16, 1'b0, 1'b0);
			6'd38: u = mk(OP_ADD, S_M, S_T, M_M, SH24, 1'b0, 1'b1);
			default: begin
				if (pc >= PC_EVAL_A && pc < PC_EVAL_A + EVAL_LEN)
					u = eval_uop(4'(pc - PC_EVAL_A));
				else
					u = eval_uop(4'(pc - PC_EVAL_B));
			end
		endcase
		return u;
	endfunction

endpackage

// ===== design/mks_stream_if.sv =====
// Valid/ready stream interfaces for input items and result items
interface mks_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] biomass;
	logic signed [31:0] oxygen;
	logic signed [31:0] glucose;
	logic signed [31:0] muconate;
	logic signed [31:0] carbon_dioxide;
	logic [31:0] start_time;
	logic [31:0] advance_time;

	modport source(output valid, biomass, oxygen, glucose, muconate, carbon_dioxide,
		start_time, advance_time, input ready);
	modport sink(input valid, biomass, oxygen, glucose, muconate, carbon_dioxide,
		start_time, advance_time, output ready);
endinterface

interface mks_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] biomass_next;
	logic signed [31:0] oxygen_next;
	logic signed [31:0] glucose_next;
	logic signed [31:0] muconate_next;
	logic signed [31:0] carbon_dioxide_next;
	logic [1:0] error_flags;

	modport source(output valid, biomass_next, oxygen_next, glucose_next, muconate_next,
		carbon_dioxide_next, error_flags, input ready);
	modport sink(input valid, biomass_next, oxygen_next, glucose_next, muconate_next,
		carbon_dioxide_next, error_flags, output ready);
endinterface

// ===== design/monod_kinetics_midpoint_step.sv =====
// The step count is ceil(advance_time / step_size), fewer when a step leaves the state unchanged.
// Each step runs 38 micro-ops through one shared unit.
// One item in flight: a new item is taken only when the sequencer is idle.
// Asynchronous active-low reset clears control state and restores register defaults.
module monod_kinetics_midpoint_step import mks_pkg::*; (
	input logic clk,
	input logic arst_n,
	mks_in_if.sink sample,
	mks_out_if.source result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_NDIV = 3'd2;
	localparam logic [2:0] S_NWAIT = 3'd3;
	localparam logic [2:0] S_FETCH = 3'd4;
	localparam logic [2:0] S_ISSUE = 3'd5;
	localparam logic [2:0] S_WAIT = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	cfg_t cfg;
	alu_req_t req;
	alu_rsp_t rsp;
	uop_t uop;

	logic [2:0] st_q;
	logic [1:0] ld_q;
	pc_t pc_q;
	logic [32:0] n_q;
	logic [1:0] flags_q;
	logic same_q;
	logic res_valid_q;
	logic signed [31:0] x_q, g_q, m_q, o_q, c_q;
	logic [31:0] adv_q;
	logic signed [31:0] mem_q [16];
	logic signed [31:0] rda_q, rdb_q;

	logic we;
	maddr_t wa;
	logic signed [31:0] wd;
	logic out_free;
	logic all_same;

	mks_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	mks_alu u_alu (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// operand select: scratch memory, a register or a constant
	function automatic logic signed [32:0] opnd(src_t s, logic signed [31:0] mv, cfg_t c);
		logic signed [32:0] v;
		unique case (s)
			S_DT: v = {1'b0, c.step_size};
			S_YX: v = {1'b0, c.growth_yield};
			S_YP: v = {1'b0, c.product_yield};
			S_MU: v = {1'b0, c.max_uptake};
			S_CAP: v = {1'b0, c.biomass_cap};
			S_KS: v = {1'b0, c.glucose_half_sat};
			S_KO: v = {1'b0, c.oxygen_half_sat};
			S_ONE: v = ONE_Q24;
			S_ZERO: v = 33'sd0;
			default: v = {mv[31], mv};
		endcase
		return v;
	endfunction

	assign uop = uop_rom(pc_q);
	assign sample.ready = (st_q == S_IDLE);
	assign out_free = !res_valid_q || result.ready;
	assign all_same = same_q && rsp.same;

	// request to the shared unit
	always_comb begin
		req.start = (st_q == S_ISSUE) || (st_q == S_NDIV);
		req.sh = uop.sh;
		req.plain = uop.plain;
		if (st_q == S_NDIV) begin
			req.op = OP_NDIV;
			req.a = $signed(33'({1'b0, adv_q} + {1'b0, cfg.step_size} - 33'd1));
			req.b = {1'b0, cfg.step_size};
		end else begin
			req.op = uop.op;
			req.a = opnd(uop.sa, rda_q, cfg);
			req.b = opnd(uop.sb, rdb_q, cfg);
		end
	end

	// scratch write port
	always_comb begin
		we = 1'b0;
		wa = uop.dst;
		wd = rsp.res;
		if (st_q == S_LOAD) begin
			we = 1'b1;
			unique case (ld_q)
				2'd0: begin wa = M_X; wd = x_q; end
				2'd1: begin wa = M_G; wd = g_q; end
				2'd2: begin wa = M_M; wd = m_q; end
				default: begin wa = M_O; wd = o_q; end
			endcase
		end else if (st_q == S_WAIT && rsp.done) begin
			we = 1'b1;
		end
	end

	// scratch memory, registered reads
	always_ff @(posedge clk) begin
		if (we)
			mem_q[wa] <= wd;
		rda_q <= mem_q[uop.sa[3:0]];
		rdb_q <= mem_q[uop.sb[3:0]];
	end

	// item capture, shadow copies of the state and result payload
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && sample.valid) begin
			x_q <= sample.biomass;
			o_q <= sample.oxygen;
			g_q <= sample.glucose;
			m_q <= sample.muconate;
			c_q <= sample.carbon_dioxide;
			adv_q <= sample.advance_time;
		end else if (st_q == S_WAIT && rsp.done) begin
			if (uop.dst == M_X) x_q <= rsp.res;
			if (uop.dst == M_G) g_q <= rsp.res;
			if (uop.dst == M_M) m_q <= rsp.res;
		end
		if (st_q == S_DONE && out_free) begin
			result.biomass_next <= x_q;
			result.oxygen_next <= o_q;
			result.glucose_next <= g_q;
			result.muconate_next <= m_q;
			result.carbon_dioxide_next <= c_q;
			result.error_flags <= flags_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ld_q <= 2'd0;
			pc_q <= PC_FE;
			n_q <= 33'd0;
			flags_q <= 2'b00;
			same_q <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			if (st_q == S_DONE && out_free)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;

			unique case (st_q)
				S_IDLE: begin
					if (sample.valid) begin
						flags_q <= 2'b00;
						ld_q <= 2'd0;
						st_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					ld_q <= ld_q + 2'd1;
					if (ld_q == 2'd3) begin
						if (cfg.step_size == 32'd0) begin
							flags_q <= FLAG_ZERO_STEP;
							st_q <= S_DONE;
						end else begin
							st_q <= S_NDIV;
						end
					end
				end
				S_NDIV: st_q <= S_NWAIT;
				S_NWAIT: begin
					if (rsp.done) begin
						n_q <= rsp.quot;
						pc_q <= PC_FE;
						same_q <= 1'b1;
						st_q <= (rsp.quot == 33'd0) ? S_DONE : S_FETCH;
					end
				end
				S_FETCH: st_q <= S_ISSUE;
				S_ISSUE: st_q <= S_WAIT;
				S_WAIT: begin
					if (rsp.done) begin
						if (rsp.sat)
							flags_q <= flags_q | FLAG_SAT;
						if (uop.chk)
							same_q <= all_same;
						if (pc_q == PC_LAST) begin
							n_q <= n_q - 33'd1;
							if (all_same || n_q == 33'd1) begin
								st_q <= S_DONE;
							end else begin
								pc_q <= PC_STEP;
								same_q <= 1'b1;
								st_q <= S_FETCH;
							end
						end else begin
							pc_q <= pc_q + 6'd1;
							st_q <= S_FETCH;
						end
					end
				end
				S_DONE: begin
					if (out_free)
						st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid = res_valid_q;
endmodule

// ===== design/mks_cfg.sv =====
// APB register bank holding step size and kinetic constants
module mks_cfg import mks_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output cfg_t cfg
);
	cfg_t cfg_q;
	logic wr;
	logic [2:0] idx;

	assign wr = psel && penable && pwrite;
	assign idx = paddr[4:2];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size <= RST_STEP_SIZE;
			cfg_q.growth_yield <= RST_GROWTH_YIELD;
			cfg_q.product_yield <= RST_PRODUCT_YIELD;
			cfg_q.max_uptake <= RST_MAX_UPTAKE;
			cfg_q.biomass_cap <= RST_BIOMASS_CAP;
			cfg_q.glucose_half_sat <= RST_GLUCOSE_HALF_SAT;
			cfg_q.oxygen_half_sat <= RST_OXYGEN_HALF_SAT;
		end else if (wr) begin
			unique case (idx)
				REG_STEP_SIZE: cfg_q.step_size <= pwdata;
				REG_GROWTH_YIELD: cfg_q.growth_yield <= pwdata;
				REG_PRODUCT_YIELD: cfg_q.product_yield <= pwdata;
				REG_MAX_UPTAKE: cfg_q.max_uptake <= pwdata;
				REG_BIOMASS_CAP: cfg_q.biomass_cap <= pwdata;
				REG_GLUCOSE_HALF_SAT: cfg_q.glucose_half_sat <= pwdata;
				REG_OXYGEN_HALF_SAT: cfg_q.oxygen_half_sat <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_STEP_SIZE: prdata = cfg_q.step_size;
			REG_GROWTH_YIELD: prdata = cfg_q.growth_yield;
			REG_PRODUCT_YIELD: prdata = cfg_q.product_yield;
			REG_MAX_UPTAKE: prdata = cfg_q.max_uptake;
			REG_BIOMASS_CAP: prdata = cfg_q.biomass_cap;
			REG_GLUCOSE_HALF_SAT: prdata = cfg_q.glucose_half_sat;
			REG_OXYGEN_HALF_SAT: prdata = cfg_q.oxygen_half_sat;
			default: prdata = 32'd0;
		endcase
	end
endmodule

// ===== design/mks_alu.sv =====
// Shared arithmetic unit: saturating multiply, add/sub and radix-2 divider
module mks_alu import mks_pkg::*; (
	input logic clk,
	input logic arst_n,
	input alu_req_t req,
	output alu_rsp_t rsp
);
	localparam logic [2:0] A_IDLE = 3'd0;
	localparam logic [2:0] A_MULF = 3'd1;
	localparam logic [2:0] A_DCHK = 3'd2;
	localparam logic [2:0] A_DITER = 3'd3;
	localparam logic [2:0] A_DFIN = 3'd4;

	logic [2:0] st_q;
	logic done_q;
	logic [65:0] prod_q;
	logic neg_q;
	shsel_t sh_q;
	logic ndiv_q;
	logic [40:0] mn_q;
	logic [40:0] md_q;
	logic [41:0] rem_q;
	logic [32:0] shr_q;
	logic [32:0] quo_q;
	logic [5:0] cnt_q;
	logic signed [31:0] res_q;
	logic sat_q;
	logic same_q;

	logic [32:0] ma, mb;
	logic signed [40:0] nn, dd;
	logic signed [33:0] sum;
	logic [65:0] pshift;
	logic [41:0] r2;
	logic r_ge;

	// operand magnitudes and divider setup
	always_comb begin
		ma = req.a[32] ? 33'(-req.a) : req.a;
		mb = req.b[32] ? 33'(-req.b) : req.b;
		nn = {req.a[31], req.a[31:0], 8'b0};
		dd = req.plain ? $signed({9'b0, req.b[31:0]}) : nn + $signed({9'b0, req.b[31:0]});
		if (req.op == OP_SUB)
			sum = {req.a[32], req.a} - {req.b[32], req.b};
		else
			sum = {req.a[32], req.a} + {req.b[32], req.b};
	end

	// product alignment
	always_comb begin
		unique case (sh_q)
			SH16: pshift = prod_q >> 16;
			SH17: pshift = prod_q >> 17;
			default: pshift = prod_q >> 24;
		endcase
	end

	// one restoring step
	assign r2 = {rem_q[40:0], shr_q[32]};
	assign r_ge = r2 >= {1'b0, md_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= A_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				A_IDLE: begin
					if (req.start) begin
						priority case (req.op)
							OP_MUL: st_q <= A_MULF;
							OP_ADD, OP_SUB: done_q <= 1'b1;
							default: st_q <= A_DCHK;
						endcase
					end
				end
				A_MULF: begin
					done_q <= 1'b1;
					st_q <= A_IDLE;
				end
				A_DCHK: begin
					if (!ndiv_q && (md_q == 41'd0 || {7'b0, mn_q} >= {md_q, 7'b0})) begin
						done_q <= 1'b1;
						st_q <= A_IDLE;
					end else begin
						st_q <= A_DITER;
					end
				end
				A_DITER: begin
					if (cnt_q == 6'd1)
						st_q <= A_DFIN;
				end
				A_DFIN: begin
					done_q <= 1'b1;
					st_q <= A_IDLE;
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			A_IDLE: begin
				if (req.start) begin
					sh_q <= req.sh;
					ndiv_q <= (req.op == OP_NDIV);
					sat_q <= 1'b0;
					prod_q <= ma * mb;
					neg_q <= req.a[32] ^ req.b[32];
					if (req.op == OP_NDIV) begin
						mn_q <= {8'b0, req.a};
						md_q <= {9'b0, req.b[31:0]};
					end else begin
						mn_q <= nn[40] ? 41'(-nn) : 41'(nn);
						md_q <= dd[40] ? 41'(-dd) : 41'(dd);
						if (req.op == OP_DIVQ)
							neg_q <= nn[40] ^ dd[40];
					end
					// add and subtract finish here
					if (sum > 34'sd2147483647) begin
						res_q <= 32'h7FFF_FFFF;
						sat_q <= (req.op == OP_ADD || req.op == OP_SUB);
					end else if (sum < -34'sd2147483648) begin
						res_q <= 32'h8000_0000;
						sat_q <= (req.op == OP_ADD || req.op == OP_SUB);
					end else begin
						res_q <= sum[31:0];
					end
					same_q <= (sum[31:0] == req.a[31:0]) && (sum <= 34'sd2147483647)
						&& (sum >= -34'sd2147483648)
						|| (sum > 34'sd2147483647 && req.a[31:0] == 32'h7FFF_FFFF)
						|| (sum < -34'sd2147483648 && req.a[31:0] == 32'h8000_0000);
				end
			end
			A_MULF: begin
				if (neg_q) begin
					if (pshift > 66'd2147483648) begin
						res_q <= 32'h8000_0000;
						sat_q <= 1'b1;
					end else begin
						res_q <= 32'(32'd0 - pshift[31:0]);
					end
				end else if (pshift > 66'd2147483647) begin
					res_q <= 32'h7FFF_FFFF;
					sat_q <= 1'b1;
				end else begin
					res_q <= pshift[31:0];
				end
			end
			A_DCHK: begin
				quo_q <= 33'd0;
				if (ndiv_q) begin
					rem_q <= 42'd0;
					shr_q <= mn_q[32:0];
					cnt_q <= 6'd33;
				end else begin
					rem_q <= {8'b0, mn_q[40:7]};
					shr_q <= {mn_q[6:0], 26'b0};
					cnt_q <= 6'd31;
					// zero divisor gives zero, integer part of 128 or more saturates
					if (md_q == 41'd0) begin
						res_q <= 32'sd0;
					end else if ({7'b0, mn_q} >= {md_q, 7'b0}) begin
						res_q <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
						sat_q <= 1'b1;
					end
				end
			end
			A_DITER: begin
				rem_q <= r_ge ? 42'(r2 - {1'b0, md_q}) : r2;
				quo_q <= {quo_q[31:0], r_ge};
				shr_q <= {shr_q[31:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
			end
			A_DFIN: begin
				res_q <= neg_q ? 32'(32'd0 - {1'b0, quo_q[30:0]}) : {1'b0, quo_q[30:0]};
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.res = res_q;
	assign rsp.quot = quo_q;
	assign rsp.sat = sat_q;
	assign rsp.same = same_q;
endmodule

// ===== design/mks_checker.sv =====
// Port-level checks of the integrator, bound to the top level
`include "assert_macros.svh"

module mks_checker (
	input logic clk,
	input logic arst_n,
	mks_in_if.sink sample,
	mks_out_if.source result
);
	// busy right after taking an item
	`ASSERT_NEXT(a_busy_after_accept, sample.valid && sample.ready, !sample.ready)

	// a result never shows up the cycle after an item is taken
	`ASSERT_NEXT(a_no_instant_result, sample.valid && sample.ready, !$rose(result.valid))

	// a rejected zero step runs no arithmetic, so it cannot saturate
	`ASSERT_IMPL(a_zero_step_clean, result.valid && result.error_flags[1], !result.error_flags[0])

	// a stalled result holds
	`ASSERT_NEXT(a_result_hold, result.valid && !result.ready,
		result.valid && $stable(result.biomass_next) && $stable(result.error_flags))
endmodule

bind monod_kinetics_midpoint_step mks_checker u_mks_checker (
	.clk(clk),
	.arst_n(arst_n),
	.sample(sample),
	.result(result)
);

// ===== tb/tb_monod_kinetics_midpoint_step.sv =====
// Testbench for the Monod kinetics midpoint integrator: stream stimulus, predictor and checks
`timescale 1ns / 100ps
module tb_monod_kinetics_midpoint_step;
	import mks_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam longint U32_MAX = 64'hFFFF_FFFF;

	typedef struct {
		logic signed [31:0] biomass;
		logic signed [31:0] oxygen;
		logic signed [31:0] glucose;
		logic signed [31:0] muconate;
		logic signed [31:0] carbon_dioxide;
		logic [31:0] start_time;
		logic [31:0] advance_time;
	} sample_t;

	typedef struct {
		logic signed [31:0] biomass;
		logic signed [31:0] oxygen;
		logic signed [31:0] glucose;
		logic signed [31:0] muconate;
		logic signed [31:0] carbon_dioxide;
		logic [1:0] flags;
	} conc_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	mks_in_if smp();
	mks_out_if res();

	monod_kinetics_midpoint_step dut (
		.clk(clk), .arst_n(arst_n), .sample(smp), .result(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	cfg_t kin;
	conc_t conc_expected[$];
	int mismatches;
	int send_idle;
	int recv_idle;
	int recv_hold;
	int quiet_cycles;

	always #5 clk = ~clk;

	// saturate to signed 32 bits
	function automatic longint clamp32(longint v, inout logic [1:0] fl);
		if (v > 64'sd2147483647) begin
			fl |= FLAG_SAT;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			fl |= FLAG_SAT;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// (a*b)>>sh on magnitudes, truncated toward zero
	function automatic longint fxmul(longint a, longint b, int sh, inout logic [1:0] fl);
		logic neg;
		longint unsigned ma, mb, p;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p = (ma * mb) >> sh;
		if (neg) begin
			if (p > 64'd2147483648) begin
				fl |= FLAG_SAT;
				return -64'sd2147483648;
			end
			return -longint'(p);
		end
		if (p > 64'd2147483647) begin
			fl |= FLAG_SAT;
			return 64'sd2147483647;
		end
		return longint'(p);
	endfunction

	// quotient with 24 fractional bits, zero divisor gives zero
	function automatic longint fxdiv(longint n, longint d, inout logic [1:0] fl);
		logic neg;
		longint unsigned mn, md, q, r;
		if (d == 0) return 0;
		neg = (n < 0) != (d < 0);
		mn = (n < 0) ? -n : n;
		md = (d < 0) ? -d : d;
		q = mn / md;
		if (q >= 128) begin
			fl |= FLAG_SAT;
			return neg ? -64'sd2147483648 : 64'sd2147483647;
		end
		r = mn % md;
		for (int i = 0; i < 24; i++) begin
			q = q << 1;
			r = r << 1;
			if (r >= md) begin
				r -= md;
				q |= 1;
			end
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	// growth, uptake and production rates at one point
	task automatic kinetic_rates(input longint x, o, g, output longint rx, rg, rm,
		inout logic [1:0] fl);
		longint fs, fe, qs, ratio, logi, up;
		fs = fxdiv(g * 256, g * 256 + longint'(kin.glucose_half_sat), fl);
		fe = fxdiv(o * 256, o * 256 + longint'(kin.oxygen_half_sat), fl);
		qs = fxmul(fxmul(longint'(kin.max_uptake), fs, 24, fl), fe, 24, fl);
		ratio = fxdiv(x * 256, longint'(kin.biomass_cap), fl);
		logi = clamp32(longint'(ONE_Q24) - ratio, fl);
		rx = fxmul(fxmul(fxmul(longint'(kin.growth_yield), qs, 24, fl), x, 24, fl),
			logi, 24, fl);
		up = fxmul(qs, x, 24, fl);
		rg = clamp32(-up, fl);
		rm = fxmul(fxmul(longint'(kin.product_yield), qs, 24, fl), x, 24, fl);
	endtask

	// concentrations after integrating one sample over its span
	task automatic integrate(input sample_t s, output conc_t e);
		longint x, o, g, m, dt, rx, rg, rm, hx, hg, nx, ng, nm;
		longint unsigned steps;
		logic [1:0] fl;
		x = s.biomass;
		o = s.oxygen;
		g = s.glucose;
		m = s.muconate;
		dt = longint'(kin.step_size);
		fl = 2'b00;
		if (kin.step_size == 0) begin
			fl |= FLAG_ZERO_STEP;
		end else begin
			steps = (longint'(s.advance_time) + dt - 1) / dt;
			while (steps > 0) begin
				kinetic_rates(x, o, g, rx, rg, rm, fl);
				hx = clamp32(x + fxmul(rx, dt, 17, fl), fl);
				hg = clamp32(g + fxmul(rg, dt, 17, fl), fl);
				void'(clamp32(m + fxmul(rm, dt, 17, fl), fl));
				kinetic_rates(hx, o, hg, rx, rg, rm, fl);
				nx = clamp32(x + fxmul(rx, dt, 16, fl), fl);
				ng = clamp32(g + fxmul(rg, dt, 16, fl), fl);
				nm = clamp32(m + fxmul(rm, dt, 16, fl), fl);
				steps--;
				if (nx == x && ng == g && nm == m) break;
				x = nx;
				g = ng;
				m = nm;
			end
		end
		e.biomass = x[31:0];
		e.oxygen = s.oxygen;
		e.glucose = g[31:0];
		e.muconate = m[31:0];
		e.carbon_dioxide = s.carbon_dioxide;
		e.flags = fl;
	endtask

	// register write: setup cycle, then access cycle
	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_STEP_SIZE: kin.step_size = val;
			REG_GROWTH_YIELD: kin.growth_yield = val;
			REG_PRODUCT_YIELD: kin.product_yield = val;
			REG_MAX_UPTAKE: kin.max_uptake = val;
			REG_BIOMASS_CAP: kin.biomass_cap = val;
			REG_GLUCOSE_HALF_SAT: kin.glucose_half_sat = val;
			default: kin.oxygen_half_sat = val;
		endcase
	endtask

	task automatic load_kinetics(logic [31:0] dt, yx, yp, mu, cap, ks, ko);
		reg_write(REG_STEP_SIZE, dt);
		reg_write(REG_GROWTH_YIELD, yx);
		reg_write(REG_PRODUCT_YIELD, yp);
		reg_write(REG_MAX_UPTAKE, mu);
		reg_write(REG_BIOMASS_CAP, cap);
		reg_write(REG_GLUCOSE_HALF_SAT, ks);
		reg_write(REG_OXYGEN_HALF_SAT, ko);
	endtask

	// offer one item, predict it, wait for acceptance
	task automatic send_sample(sample_t s);
		conc_t e;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			smp.valid <= 1'b0;
			@(negedge clk);
		end
		smp.biomass <= s.biomass;
		smp.oxygen <= s.oxygen;
		smp.glucose <= s.glucose;
		smp.muconate <= s.muconate;
		smp.carbon_dioxide <= s.carbon_dioxide;
		smp.start_time <= s.start_time;
		smp.advance_time <= s.advance_time;
		smp.valid <= 1'b1;
		integrate(s, e);
		conc_expected.insert(conc_expected.size(), e);
		do @(posedge clk); while (!smp.ready);
	endtask

	// wait until all results are in and the block is idle
	task automatic drain;
		@(negedge clk);
		smp.valid <= 1'b0;
		wait (conc_expected.size() == 0);
		repeat (20) @(negedge clk);
	endtask

	function automatic sample_t mk_sample(logic [31:0] x, o, g, m, c, adv);
		sample_t s;
		s.biomass = x;
		s.oxygen = o;
		s.glucose = g;
		s.muconate = m;
		s.carbon_dioxide = c;
		s.start_time = $urandom;
		s.advance_time = adv;
		return s;
	endfunction

	// span covering a few steps at most
	function automatic logic [31:0] pick_span();
		longint lim;
		if ($urandom_range(19) == 0) return 0;
		if (kin.step_size == 0) return $urandom;
		lim = 3 * longint'(kin.step_size);
		if (lim > U32_MAX) lim = U32_MAX;
		return 32'($urandom_range(32'(lim), 0));
	endfunction

	// mostly plausible concentrations, some raw noise
	function automatic sample_t random_sample();
		sample_t s;
		if ($urandom_range(4) == 0) begin
			s = mk_sample($urandom, $urandom, $urandom, $urandom, $urandom, pick_span());
		end else begin
			s = mk_sample($urandom_range(9 << 16, 0), $urandom_range(1 << 15, 0),
				$urandom_range(25 << 16, 0), $urandom_range(20 << 16, 0), $urandom,
				pick_span());
			if ($urandom_range(9) == 0) s.glucose = -s.glucose;
			if ($urandom_range(9) == 0) s.oxygen = -s.oxygen;
		end
		return s;
	endfunction

	task automatic test_directed;
		sample_t s;
		send_sample(mk_sample(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'd0));
		send_sample(mk_sample(1 << 16, 1 << 13, 10 << 16, 0, 5 << 16, 32'd655));
		send_sample(mk_sample(2 << 16, 1 << 12, 5 << 16, 3 << 16, -1, 32'd1965));
		// zero biomass: no change after one step, stops early on a long span
		send_sample(mk_sample(0, 1 << 14, 8 << 16, 1 << 16, 7, 32'd655000));
		// zero span with live kinetics
		send_sample(mk_sample(3 << 16, 1 << 14, 5 << 16, 1, 2, 32'd0));
		send_sample(mk_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd655));
		send_sample(mk_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'd1310));
		send_sample(mk_sample(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0,
			32'h8000_0000, 32'd1));
		// glucose just below minus the half saturation: tiny divisor
		send_sample(mk_sample(1 << 16, 1 << 14, -32'sd4719, 0, 0, 32'd655));
		s = mk_sample(4 << 16, 1 << 10, 1 << 16, 0, 0, 32'd600);
		s.start_time = 32'hFFFF_FFFF;
		send_sample(s);
		drain();
	endtask

	task automatic test_zero_step;
		reg_write(REG_STEP_SIZE, 32'd0);
		send_sample(mk_sample(1 << 16, 1 << 13, 10 << 16, 0, 5, 32'd655));
		send_sample(mk_sample($urandom, $urandom, $urandom, $urandom, $urandom, 32'hFFFF_FFFF));
		send_sample(mk_sample(1, 2, 3, 4, 5, 32'd0));
		repeat (10) send_sample(random_sample());
		drain();
	endtask

	task automatic test_extreme_kinetics;
		load_kinetics(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(mk_sample(1 << 16, 1 << 16, 1 << 16, 0, 0, 32'hFFFF_FFFF));
		send_sample(mk_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 32'd1));
		repeat (20) send_sample(random_sample());
		drain();
		load_kinetics(32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0);
		send_sample(mk_sample(1 << 16, 0, 0, 0, 0, 32'd3));
		send_sample(mk_sample(-32'sd65536, 1 << 16, 1 << 16, 1, 1, 32'd2));
		repeat (20) send_sample(mk_sample($urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom_range(3, 0)));
		drain();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				drain();
				if ($urandom_range(2) == 0)
					load_kinetics($urandom, $urandom, $urandom, $urandom,
						$urandom_range(32'hFFFF_FFFF, 1), $urandom, $urandom);
				else
					load_kinetics($urandom_range(1 << 16, 1), $urandom_range(1 << 25, 0),
						$urandom_range(1 << 25, 0), $urandom_range(1 << 27, 0),
						$urandom_range(1 << 28, 1 << 22), $urandom_range(1 << 22, 0),
						$urandom_range(1 << 16, 0));
			end
			send_sample(random_sample());
		end
		drain();
	endtask

	// receiver stalls long while the sender keeps offering
	task automatic test_backpressure;
		load_kinetics(RST_STEP_SIZE, RST_GROWTH_YIELD, RST_PRODUCT_YIELD, RST_MAX_UPTAKE,
			RST_BIOMASS_CAP, RST_GLUCOSE_HALF_SAT, RST_OXYGEN_HALF_SAT);
		recv_hold = 3000;
		repeat (6) send_sample(random_sample());
		drain();
	endtask

	// receiver ready, with random idling and hold-off
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		conc_t e;
		if (arst_n && res.valid && res.ready) begin
			if (conc_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result item");
			end else begin
				e = conc_expected.pop_front();
				if (res.biomass_next !== e.biomass || res.oxygen_next !== e.oxygen ||
					res.glucose_next !== e.glucose || res.muconate_next !== e.muconate ||
					res.carbon_dioxide_next !== e.carbon_dioxide ||
					res.error_flags !== e.flags) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h %h %h %h %h %b got %h %h %h %h %h %b",
							e.biomass, e.oxygen, e.glucose, e.muconate,
							e.carbon_dioxide, e.flags, res.biomass_next,
							res.oxygen_next, res.glucose_next, res.muconate_next,
							res.carbon_dioxide_next, res.error_flags);
				end
			end
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		smp.valid = 1'b0;
		smp.biomass = '0;
		smp.oxygen = '0;
		smp.glucose = '0;
		smp.muconate = '0;
		smp.carbon_dioxide = '0;
		smp.start_time = '0;
		smp.advance_time = '0;
		res.ready = 1'b0;
		mismatches = 0;
		quiet_cycles = 0;
		recv_hold = 0;
		send_idle = 13;
		recv_idle = 57;
		kin.step_size = RST_STEP_SIZE;
		kin.growth_yield = RST_GROWTH_YIELD;
		kin.product_yield = RST_PRODUCT_YIELD;
		kin.max_uptake = RST_MAX_UPTAKE;
		kin.biomass_cap = RST_BIOMASS_CAP;
		kin.glucose_half_sat = RST_GLUCOSE_HALF_SAT;
		kin.oxygen_half_sat = RST_OXYGEN_HALF_SAT;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_zero_step();
		test_extreme_kinetics();
		test_random(500);
		send_idle = 57;
		recv_idle = 13;
		test_backpressure();
		test_random(500);
		send_idle = 0;
		recv_idle = 0;
		test_random(400);

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
